@@ hdl/krdd_pkg.sv @@
// Package with shared constants and types for the key-ramped differential drive.
`default_nettype none

package krdd_pkg;

  // Field widths.
  localparam int unsigned CfgW     = 10;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned LevelW   = 11;
  localparam int unsigned SumW     = 12;
  localparam int unsigned EvTypeW  = 16;
  localparam int unsigned KeyCodeW = 16;
  localparam int unsigned KeyValW  = 8;
  localparam int unsigned NumKeys  = 6;

  // Action codes.
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Event type and key values that the command decode compares against.
  localparam logic [EvTypeW-1:0] EV_KEY      = 16'd1;
  localparam logic [KeyValW-1:0] KVAL_PRESS  = 8'd1;
  localparam logic [KeyValW-1:0] KVAL_REPEAT = 8'd2;

  // Key codes.
  localparam logic [KeyCodeW-1:0] KEY_CODE_FWD    = 16'd17;
  localparam logic [KeyCodeW-1:0] KEY_CODE_LEFT   = 16'd30;
  localparam logic [KeyCodeW-1:0] KEY_CODE_BACK   = 16'd31;
  localparam logic [KeyCodeW-1:0] KEY_CODE_RIGHT  = 16'd32;
  localparam logic [KeyCodeW-1:0] KEY_CODE_LSHIFT = 16'd42;
  localparam logic [KeyCodeW-1:0] KEY_CODE_RSHIFT = 16'd54;

  // Bit positions in the held-key flags.
  localparam int unsigned HK_FWD    = 0;
  localparam int unsigned HK_LEFT   = 1;
  localparam int unsigned HK_BACK   = 2;
  localparam int unsigned HK_RIGHT  = 3;
  localparam int unsigned HK_LSHIFT = 4;
  localparam int unsigned HK_RSHIFT = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_RAMP_STEP  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_DECAY_STEP = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_FULL_SCALE = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_CLIP_LIMIT = 8'd3;

  // Configuration reset values.
  localparam logic [CfgW-1:0] RST_RAMP_STEP  = 10'd15;
  localparam logic [CfgW-1:0] RST_DECAY_STEP = 10'd20;
  localparam logic [CfgW-1:0] RST_FULL_SCALE = 10'd500;
  localparam logic [CfgW-1:0] RST_CLIP_LIMIT = 10'd500;

  typedef logic signed [LevelW-1:0] level_t;

  // Step settings shared by both axes.
  typedef struct packed {
    logic [CfgW-1:0] ramp_step;
    logic [CfgW-1:0] decay_step;
    logic [CfgW-1:0] full_scale;
  } krdd_step_cfg_t;

  // Per-axis key control.
  typedef struct packed {
    logic pos_key;
    logic neg_key;
    logic hold;
  } krdd_axis_ctl_t;

endpackage

`default_nettype wire

@@ hdl/krdd_if.sv @@
// Channel interfaces for commands, drive results and configuration writes.
`default_nettype none

interface krdd_cmd_if;
  import krdd_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [EvTypeW-1:0]  event_type;
  logic [KeyCodeW-1:0] key_code;
  logic [KeyValW-1:0]  key_value;

  modport source (output valid, action, event_type, key_code, key_value, input ready);
  modport sink   (input valid, action, event_type, key_code, key_value, output ready);
endinterface

interface krdd_drive_if;
  import krdd_pkg::*;
  logic   valid;
  logic   ready;
  level_t left_drive;
  level_t right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

interface krdd_cfg_if;
  import krdd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/krdd_axis.sv @@
// One drive axis: target from two opposing keys and a slew-limited level update.
`default_nettype none

module krdd_axis (
  input  krdd_pkg::krdd_step_cfg_t cfg,
  input  krdd_pkg::krdd_axis_ctl_t ctl,
  input  krdd_pkg::level_t         level,
  output krdd_pkg::level_t         level_next
);
  import krdd_pkg::*;

  logic signed [SumW-1:0] tmax_s;
  logic signed [SumW-1:0] target;
  logic signed [SumW-1:0] step_s;
  logic signed [SumW-1:0] level_s;
  logic signed [SumW-1:0] diff;
  logic signed [SumW-1:0] up_sum;
  logic signed [SumW-1:0] down_sum;

  // Target is plus or minus full_scale; opposing keys cancel.
  always_comb begin
    tmax_s = $signed({2'b00, cfg.full_scale});
    if (ctl.pos_key && !ctl.neg_key) begin
      target = tmax_s;
    end else if (ctl.neg_key && !ctl.pos_key) begin
      target = -tmax_s;
    end else begin
      target = '0;
    end
  end

  // Ramp toward a nonzero target, decay toward zero.
  assign step_s   = $signed({2'b00, (target != '0) ? cfg.ramp_step : cfg.decay_step});
  assign level_s  = SumW'(level);
  assign diff     = target - level_s;
  assign up_sum   = level_s + step_s;
  assign down_sum = level_s - step_s;

  // Hold when ctl.hold is set, else move one step, or snap onto the target when within one step.
  always_comb begin
    priority if (ctl.hold) begin
      level_next = level;
    end else if (diff > step_s) begin
      level_next = up_sum[LevelW-1:0];
    end else if (diff < -step_s) begin
      level_next = down_sum[LevelW-1:0];
    end else begin
      level_next = target[LevelW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/key_ramped_differential_drive_top.sv @@
// Top level of the key-ramped differential drive mixer.
//
//  Channel | Direction | Payload                                   | Transaction
//  cmd     | in        | action, event_type, key_code, key_value   | valid && ready
//  drive   | out       | left_drive, right_drive (one per tick)    | valid && ready
//  cfg     | in        | index, data (write only, always ready)    | valid && ready
//
// One command transaction can be taken every cycle while cmd.ready is high. Key
// events update the held keys in the cycle they are taken; a tick updates both
// levels at once and its drive result passes a mixing stage and the output register.
// Reset clears held keys, levels, pending results and loads the register defaults.
// While the output register is full and not taken, cmd.ready drops only once the
// mixing stage also holds a result.
`default_nettype none

module key_ramped_differential_drive_top (
  input  logic              clk,
  input  logic              rst,
  krdd_cmd_if.sink          cmd,
  krdd_drive_if.source      drive,
  krdd_cfg_if.sink          cfg
);
  import krdd_pkg::*;

  krdd_step_cfg_t       step_cfg;
  logic [CfgW-1:0]      clip_limit;
  logic [NumKeys-1:0]   held_keys;
  logic [NumKeys-1:0]   held_keys_next;
  logic [NumKeys-1:0]   key_bit;
  level_t               forward_level;
  level_t               turn_level;
  level_t               forward_next;
  level_t               turn_next;
  krdd_axis_ctl_t       fwd_ctl;
  krdd_axis_ctl_t       turn_ctl;
  logic                 mix_valid;
  logic                 out_valid;
  level_t               left_drive;
  level_t               right_drive;
  logic                 out_free;
  logic                 cmd_acc;
  logic                 tick_acc;
  logic                 key_acc;
  logic                 shift_held;
  logic signed [SumW-1:0] sum_left;
  logic signed [SumW-1:0] sum_right;
  level_t               clip_left;
  level_t               clip_right;

  // Saturate a sum to plus or minus the clip limit.
  function automatic level_t clip_sum(input logic signed [SumW-1:0] v,
                                      input logic [CfgW-1:0] lim);
    logic signed [SumW-1:0] lim_s;
    lim_s = $signed({2'b00, lim});
    if (v > lim_s) begin
      return lim_s[LevelW-1:0];
    end else if (v < -lim_s) begin
      return LevelW'(-lim_s);
    end else begin
      return v[LevelW-1:0];
    end
  endfunction

  // Handshake.
  assign out_free  = !out_valid || drive.ready;
  assign cmd.ready = !mix_valid || out_free;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign tick_acc  = cmd_acc && (cmd.action == ACT_TICK);
  assign key_acc   = cmd_acc && (cmd.action == ACT_KEY) && (cmd.event_type == EV_KEY) &&
                     (cmd.key_value != KVAL_REPEAT);
  assign cfg.ready = 1'b1;

  // Key code decode into a held-key flag.
  always_comb begin
    key_bit = '0;
    unique case (cmd.key_code)
      KEY_CODE_FWD:    key_bit[HK_FWD]    = 1'b1;
      KEY_CODE_LEFT:   key_bit[HK_LEFT]   = 1'b1;
      KEY_CODE_BACK:   key_bit[HK_BACK]   = 1'b1;
      KEY_CODE_RIGHT:  key_bit[HK_RIGHT]  = 1'b1;
      KEY_CODE_LSHIFT: key_bit[HK_LSHIFT] = 1'b1;
      KEY_CODE_RSHIFT: key_bit[HK_RSHIFT] = 1'b1;
      default:         key_bit = '0;
    endcase
  end

  // Press sets the flag, any other non-repeat value clears it.
  always_comb begin
    held_keys_next = held_keys;
    if (key_acc) begin
      if (cmd.key_value == KVAL_PRESS) begin
        held_keys_next = held_keys | key_bit;
      end else begin
        held_keys_next = held_keys & ~key_bit;
      end
    end
  end

  // Axis controls; a held shift freezes both levels.
  assign shift_held = held_keys[HK_LSHIFT] || held_keys[HK_RSHIFT];
  assign fwd_ctl  = '{pos_key: held_keys[HK_FWD],   neg_key: held_keys[HK_BACK],
                      hold: shift_held};
  assign turn_ctl = '{pos_key: held_keys[HK_RIGHT], neg_key: held_keys[HK_LEFT],
                      hold: shift_held};

  krdd_axis u_fwd (
    .cfg        (step_cfg),
    .ctl        (fwd_ctl),
    .level      (forward_level),
    .level_next (forward_next)
  );

  krdd_axis u_turn (
    .cfg        (step_cfg),
    .ctl        (turn_ctl),
    .level      (turn_level),
    .level_next (turn_next)
  );

  // Key flags and axis levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_keys     <= '0;
      forward_level <= '0;
      turn_level    <= '0;
    end else begin
      held_keys <= held_keys_next;
      if (tick_acc) begin
        forward_level <= forward_next;
        turn_level    <= turn_next;
      end
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cfg.ramp_step  <= RST_RAMP_STEP;
      step_cfg.decay_step <= RST_DECAY_STEP;
      step_cfg.full_scale <= RST_FULL_SCALE;
      clip_limit          <= RST_CLIP_LIMIT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_RAMP_STEP:  step_cfg.ramp_step  <= cfg.data;
        REG_DECAY_STEP: step_cfg.decay_step <= cfg.data;
        REG_FULL_SCALE: step_cfg.full_scale <= cfg.data;
        REG_CLIP_LIMIT: clip_limit          <= cfg.data;
        default: ;
      endcase
    end
  end

  // Mixing stage: levels hold until the next tick is taken, so the pending
  // result reads them directly.
  assign sum_left   = SumW'(forward_level) + SumW'(turn_level);
  assign sum_right  = SumW'(forward_level) - SumW'(turn_level);
  assign clip_left  = clip_sum(sum_left, clip_limit);
  assign clip_right = clip_sum(sum_right, clip_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (tick_acc) begin
      mix_valid <= 1'b1;
    end else if (out_free) begin
      mix_valid <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && mix_valid) begin
      left_drive  <= clip_left;
      right_drive <= clip_right;
    end
  end

  assign drive.valid       = out_valid;
  assign drive.left_drive  = left_drive;
  assign drive.right_drive = right_drive;

endmodule

`default_nettype wire

@@ hdl/krdd_checker.sv @@
// Port-level checker for the drive mixer, bound to the top level.
`default_nettype none

module krdd_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   cmd_valid,
  input logic                   cmd_ready,
  input logic                   cmd_action,
  input logic                   drive_valid,
  input logic                   drive_ready,
  input logic [krdd_pkg::LevelW-1:0] left_drive,
  input logic [krdd_pkg::LevelW-1:0] right_drive
);
  import krdd_pkg::*;

  logic tick_acc;
  assign tick_acc = cmd_valid && cmd_ready && (cmd_action == ACT_TICK);

  // A stalled result stays offered unchanged.
  a_drive_hold: assert property (@(posedge clk) disable iff (rst)
    drive_valid && !drive_ready |=> drive_valid && $stable(left_drive) && $stable(right_drive))
    else $error("drive result changed while stalled");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !drive_valid)
    else $error("drive valid after reset");

  // A fresh result follows a tick transaction, through the mixing stage and the output register.
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(drive_valid) |-> $past(tick_acc, 2))
    else $error("drive result without a tick");

  // Saturation never yields the most negative code.
  a_clip_range: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (left_drive != {1'b1, {(LevelW-1){1'b0}}}) &&
                    (right_drive != {1'b1, {(LevelW-1){1'b0}}}))
    else $error("drive outside clip range");

endmodule

bind key_ramped_differential_drive_top krdd_checker u_krdd_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_action  (cmd.action),
  .drive_valid (drive.valid),
  .drive_ready (drive.ready),
  .left_drive  (drive.left_drive),
  .right_drive (drive.right_drive)
);

`default_nettype wire
